### hdl/affine_transform_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine transform unit
// Concurrent assertion wrappers sampled on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_UNIT_DEFINES_SVH
`define AFFINE_TRANSFORM_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define ATU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ATU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/atu_pkg.sv
// ----------------------------------------------------------------------------
// Affine transform unit package
// Request and response types, lane operand types and request kind codes.
// ----------------------------------------------------------------------------
package atu_pkg;

	localparam int DATA_W = 32;
	localparam int TERMS  = 3;
	localparam int LANES  = 4;
	localparam int COORDS = 3;

	localparam logic [2:0] KIND_LOAD_ROW  = 3'd0;
	localparam logic [2:0] KIND_IDENTITY  = 3'd1;
	localparam logic [2:0] KIND_TRANSLATE = 3'd2;
	localparam logic [2:0] KIND_POINT     = 3'd3;
	localparam logic [2:0] KIND_INVERSE   = 3'd4;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] row_index;
		word_t      val_a;
		word_t      val_b;
		word_t      val_c;
		word_t      val_d;
	} req_t;

	typedef struct packed {
		word_t out_x;
		word_t out_y;
		word_t out_z;
		logic  saturated;
	} rsp_t;

	typedef struct packed {
		word_t [TERMS-1:0] a;
		word_t [TERMS-1:0] b;
		word_t [TERMS-1:0] c;
		word_t [TERMS-1:0] d;
		word_t             base;
	} lane_op_t;

	typedef struct packed {
		word_t value;
		logic  sat;
	} lane_res_t;

endpackage

### hdl/affine_transform_unit.sv
// ----------------------------------------------------------------------------
// Affine transform unit
// Holds a 4x4 fixed-point matrix and maps points through it or its rigid
// inverse. Requests arrive on req_valid/req_ready/req_data and point results
// leave on rsp_valid/rsp_ready/rsp_data. Point and inverse requests give one
// response from the merge register and may follow one another every cycle
// while not stalled. Row loads and identity take effect at once and give no
// response. A translate request goes through the lanes and writes row 3
// back at the end; req_ready stays low until then. Unknown kinds are dropped.
// Four lanes (one per matrix column or row) each run three multiply pairs in
// a four-stage pipeline; the merge stage holds the response register.
// While the receiver stalls a held response, the whole pipeline freezes and
// req_ready falls. Reset empties the pipeline and sets the identity matrix.
// ----------------------------------------------------------------------------
module affine_transform_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  atu_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output atu_pkg::rsp_t rsp_data
);
	import atu_pkg::*;

	localparam word_t UNIT = word_t'(1) <<< FRAC_BITS;

	word_t     mat_q [4][4];
	logic      busy_q;
	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	logic      trans_s1, trans_s2, trans_s3, trans_s4;

	logic      en;
	logic      accept;
	logic      to_pipe;
	logic      is_trans;
	logic      writeback;
	logic      take;
	word_t     pt [TERMS];
	lane_op_t  lane_op [LANES];
	lane_res_t lane_res [LANES];
	lane_res_t [COORDS-1:0] coord_res;

	assign req_ready = en && !busy_q;
	assign accept    = req_valid && req_ready;
	assign is_trans  = (req_data.kind == KIND_TRANSLATE);
	assign to_pipe   = accept && (is_trans || req_data.kind == KIND_POINT ||
		req_data.kind == KIND_INVERSE);
	assign writeback = en && valid_s4 && trans_s4;
	assign take      = en && valid_s4 && !trans_s4;

	always_comb begin
		pt[0] = req_data.val_a;
		pt[1] = req_data.val_b;
		pt[2] = req_data.val_c;
		for (int j = 0; j < LANES; j++) begin
			for (int k = 0; k < TERMS; k++) begin
				lane_op[j].a[k] = pt[k];
				if (req_data.kind == KIND_INVERSE) begin
					lane_op[j].b[k] = mat_q[j][k];
					lane_op[j].c[k] = mat_q[3][k];
					lane_op[j].d[k] = mat_q[j][k];
				end else begin
					lane_op[j].b[k] = mat_q[k][j];
					lane_op[j].c[k] = '0;
					lane_op[j].d[k] = '0;
				end
			end
			lane_op[j].base = (req_data.kind == KIND_INVERSE) ? word_t'(0) : mat_q[3][j];
		end
	end

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		atu_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk (clk),
			.en  (en),
			.op  (lane_op[j]),
			.res (lane_res[j])
		);
	end

	always_comb begin
		for (int j = 0; j < COORDS; j++) begin
			coord_res[j] = lane_res[j];
		end
	end

	atu_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.lane      (coord_res),
		.rsp_ready (rsp_ready),
		.free      (en),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			trans_s1 <= 1'b0;
			trans_s2 <= 1'b0;
			trans_s3 <= 1'b0;
			trans_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= to_pipe;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			trans_s1 <= is_trans;
			trans_s2 <= trans_s1;
			trans_s3 <= trans_s2;
			trans_s4 <= trans_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && is_trans) begin
			busy_q <= 1'b1;
		end else if (writeback) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[r][c] <= (r == c) ? UNIT : word_t'(0);
				end
			end
		end else if (writeback) begin
			for (int c = 0; c < LANES; c++) begin
				mat_q[3][c] <= lane_res[c].value;
			end
		end else if (accept) begin
			unique case (req_data.kind)
				KIND_LOAD_ROW: begin
					mat_q[req_data.row_index][0] <= req_data.val_a;
					mat_q[req_data.row_index][1] <= req_data.val_b;
					mat_q[req_data.row_index][2] <= req_data.val_c;
					mat_q[req_data.row_index][3] <= req_data.val_d;
				end
				KIND_IDENTITY: begin
					for (int r = 0; r < 4; r++) begin
						for (int c = 0; c < 4; c++) begin
							mat_q[r][c] <= (r == c) ? UNIT : word_t'(0);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/atu_lane.sv
// ----------------------------------------------------------------------------
// Affine transform lane
// Computes base + sum(a*b) - sum(c*d) with scaled products, then saturates.
// ----------------------------------------------------------------------------
module atu_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  atu_pkg::lane_op_t    op,
	output atu_pkg::lane_res_t   res
);
	import atu_pkg::*;

	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = PROD_W - FRAC_BITS + 3;

	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam sum_t SUM_MAX = sum_t'(Q_MAX);
	localparam sum_t SUM_MIN = sum_t'(Q_MIN);

	lane_op_t  op_s1;
	prod_t     pos_s2 [TERMS];
	prod_t     neg_s2 [TERMS];
	word_t     base_s2;
	sum_t      pos_s3;
	sum_t      neg_s3;
	lane_res_t res_s4;

	sum_t      pos_sum;
	sum_t      neg_sum;
	sum_t      diff;
	lane_res_t clamped;

	function automatic sum_t scale(input prod_t p);
		prod_t t;
		t = p >>> FRAC_BITS;
		return sum_t'(t);
	endfunction

	always_comb begin
		pos_sum = sum_t'(base_s2);
		neg_sum = '0;
		for (int k = 0; k < TERMS; k++) begin
			pos_sum = pos_sum + scale(pos_s2[k]);
			neg_sum = neg_sum + scale(neg_s2[k]);
		end
	end

	always_comb begin
		diff = pos_s3 - neg_s3;
		priority if (diff > SUM_MAX) begin
			clamped.value = Q_MAX;
			clamped.sat   = 1'b1;
		end else if (diff < SUM_MIN) begin
			clamped.value = Q_MIN;
			clamped.sat   = 1'b1;
		end else begin
			clamped.value = word_t'(diff);
			clamped.sat   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op;
			for (int k = 0; k < TERMS; k++) begin
				pos_s2[k] <= $signed(op_s1.a[k]) * $signed(op_s1.b[k]);
				neg_s2[k] <= $signed(op_s1.c[k]) * $signed(op_s1.d[k]);
			end
			base_s2 <= op_s1.base;
			pos_s3  <= pos_sum;
			neg_s3  <= neg_sum;
			res_s4  <= clamped;
		end
	end

	assign res = res_s4;

endmodule

### hdl/atu_merge.sv
// ----------------------------------------------------------------------------
// Affine transform lane merge
// Gathers the coordinate lanes into one response and holds it for the receiver.
// ----------------------------------------------------------------------------
module atu_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  atu_pkg::lane_res_t [atu_pkg::COORDS-1:0] lane,
	input  logic                             rsp_ready,
	output logic                             free,
	output logic                             rsp_valid,
	output atu_pkg::rsp_t                    rsp_data
);
	import atu_pkg::*;

	logic valid_q;
	rsp_t data_q;
	rsp_t merged;

	always_comb begin
		merged.out_x     = lane[0].value;
		merged.out_y     = lane[1].value;
		merged.out_z     = lane[2].value;
		merged.saturated = lane[0].sat | lane[1].sat | lane[2].sat;
	end

	assign free = !valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= merged;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp_data  = data_q;

endmodule

### hdl/atu_checker.sv
// ----------------------------------------------------------------------------
// Affine transform unit port checker
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
`include "affine_transform_unit_defines.svh"

module atu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input atu_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input atu_pkg::rsp_t rsp_data
);
	import atu_pkg::*;

	`ATU_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !rsp_valid, "Response offered during reset.")
	`ATU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "Stalled response changed.")
	`ATU_ASSERT(a_stall_blocks_req, rsp_valid && !rsp_ready |-> !req_ready, "Request taken while the output is stalled.")
	`ATU_ASSERT(a_translate_blocks, req_valid && req_ready && req_data.kind == KIND_TRANSLATE |=> !req_ready, "Request taken during a translate.")
	`ATU_ASSERT(a_sat_extreme, rsp_valid && rsp_data.saturated |-> (rsp_data.out_x == Q_MAX || rsp_data.out_x == Q_MIN || rsp_data.out_y == Q_MAX || rsp_data.out_y == Q_MIN || rsp_data.out_z == Q_MAX || rsp_data.out_z == Q_MIN), "Saturation flag without a clamped coordinate.")

endmodule

bind affine_transform_unit atu_checker u_atu_checker (.*);
